FILE: rtl/knob_filter_soft_takeover_defines.svh
// Assertion macros shared by the knob filter RTL.
`ifndef KNOB_FILTER_SOFT_TAKEOVER_DEFINES_SVH
`define KNOB_FILTER_SOFT_TAKEOVER_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked check, masked while reset is high.
`define KFST_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("knob filter check failed");
// Clocked check that also holds during reset.
`define KFST_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("knob filter check failed");
`else
`define KFST_ASSERT(lbl, clk, rst, prop)
`define KFST_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: rtl/kfst_pkg.sv
// Shared types and constants of the knob filter with soft takeover.
`default_nettype none
package kfst_pkg;

   localparam int SAMPLE_W = 12;
   localparam int IDX_W    = 3;
   localparam int VAL_W    = 16;
   localparam int MODE_W   = 2;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK  = 12'hfff;
   localparam logic [SAMPLE_W-1:0] THRESH_RESET = 12'd200;

   // reported lock mode codes
   localparam logic [MODE_W-1:0] MODE_CAPTURE  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOCKED   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TRACKING = 2'd2;

   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_SELECT = 2'd1,
      OP_WRITE  = 2'd2,
      OP_FORCE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      LOCK_CAPTURE  = 3'b001,
      LOCK_LOCKED   = 3'b010,
      LOCK_TRACKING = 3'b100
   } lock_type;

   // sample waiting in the update stage
   typedef struct packed {
      logic                valid;
      logic                ch;
      logic [SAMPLE_W-1:0] raw;
   } filt_req_type;

   // table write wanted by the update stage
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic [VAL_W-1:0] data;
   } tbl_wr_type;

   function automatic logic [MODE_W-1:0] lock_code(lock_type st);
      logic [MODE_W-1:0] code;
      case (st)
         LOCK_CAPTURE:  code = MODE_CAPTURE;
         LOCK_LOCKED:   code = MODE_LOCKED;
         LOCK_TRACKING: code = MODE_TRACKING;
         default:       code = MODE_CAPTURE;
      endcase
      return code;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/kfst_interfaces.sv
// Valid/ready channel interfaces of the knob filter: request, response, csr.
`default_nettype none
interface kfst_req_if;
   import kfst_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 operation;
   logic [SAMPLE_W-1:0]        sample;
   logic [IDX_W-1:0]           param_index;
   logic signed [VAL_W-1:0]    write_value;
   modport source (output valid, operation, sample, param_index, write_value, input ready);
   modport sink   (input valid, operation, sample, param_index, write_value, output ready);
endinterface

interface kfst_rsp_if;
   import kfst_pkg::*;
   logic                       valid;
   logic                       ready;
   logic                       channel;
   logic [SAMPLE_W-1:0]        filtered_value;
   logic [MODE_W-1:0]          lock_mode;
   logic [IDX_W-1:0]           active_entry;
   logic signed [VAL_W-1:0]    entry_value;
   logic                       index_rejected;
   modport source (output valid, channel, filtered_value, lock_mode, active_entry,
                   entry_value, index_rejected, input ready);
   modport sink   (input valid, channel, filtered_value, lock_mode, active_entry,
                   entry_value, index_rejected, output ready);
endinterface

interface kfst_csr_if;
   import kfst_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] unlock_threshold;
   modport source (output valid, unlock_threshold, input ready);
   modport sink   (input valid, unlock_threshold, output ready);
endinterface
`default_nettype wire

FILE: rtl/kfst_filter.sv
// Per-channel IIR accumulator memory with read-modify-write update.
`default_nettype none
module kfst_filter #(
   parameter int FILTER_SHIFT = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic                          rd_ch,
   input  kfst_pkg::filt_req_type        req,
   input  logic                          commit,
   output logic [kfst_pkg::SAMPLE_W-1:0] filt_value
);
   import kfst_pkg::*;

   localparam int ACC_W = SAMPLE_W + FILTER_SHIFT;

   logic [ACC_W-1:0]        acc_mem [2];
   logic [ACC_W-1:0]        rd_data_ff;
   logic [1:0]              vld_ff;
   logic                    fwd_vld_ff;
   logic                    fwd_ch_ff;
   logic [ACC_W-1:0]        fwd_data_ff;
   logic [ACC_W-1:0]        acc_cur;
   logic [SAMPLE_W-1:0]     x;
   logic [ACC_W-1:0]        target;
   logic signed [ACC_W:0]   diff;
   logic signed [ACC_W:0]   step;
   logic [ACC_W:0]          acc_sum;
   logic [ACC_W-1:0]        acc_new;
   logic                    do_wr;

   // memory read issued when the request is taken
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= acc_mem[rd_ch];
      end
   end

   // current accumulator: last write bypass, then memory, unwritten reads zero
   always_comb begin
      if (fwd_vld_ff && (fwd_ch_ff == req.ch)) begin
         acc_cur = fwd_data_ff;
      end else if (vld_ff[req.ch]) begin
         acc_cur = rd_data_ff;
      end else begin
         acc_cur = '0;
      end
   end

   // acc += floor(((x << S) - acc) / 2^S)
   always_comb begin
      x       = req.raw ^ SAMPLE_MASK;
      target  = {x, {FILTER_SHIFT{1'b0}}};
      diff    = $signed({1'b0, target}) - $signed({1'b0, acc_cur});
      step    = diff >>> FILTER_SHIFT;
      acc_sum = {1'b0, acc_cur} + $unsigned(step);
      acc_new = acc_sum[ACC_W-1:0];
   end

   assign filt_value = acc_new[ACC_W-1 -: SAMPLE_W];
   assign do_wr      = commit && req.valid;

   // write back
   always_ff @(posedge clock) begin
      if (do_wr) begin
         acc_mem[req.ch] <= acc_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         fwd_vld_ff <= 1'b0;
      end else if (do_wr) begin
         vld_ff[req.ch] <= 1'b1;
         fwd_vld_ff     <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         fwd_ch_ff   <= req.ch;
         fwd_data_ff <= acc_new;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/kfst_table.sv
// Parameter table memory with write bypass and post-write readout.
`default_nettype none
module kfst_table #(
   parameter int NUM_ENTRIES = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rd_en,
   input  logic [kfst_pkg::IDX_W-1:0] rd_idx,
   input  kfst_pkg::tbl_wr_type       wr,
   input  logic                       commit,
   input  logic [kfst_pkg::IDX_W-1:0] rep_idx,
   output logic [kfst_pkg::VAL_W-1:0] entry_value
);
   import kfst_pkg::*;

   localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam int WW = (AW > IDX_W) ? AW : IDX_W;

   logic [VAL_W-1:0]       tbl_mem [NUM_ENTRIES];
   logic [VAL_W-1:0]       rd_data_ff;
   logic [NUM_ENTRIES-1:0] vld_ff;
   logic                   fwd_vld_ff;
   logic [IDX_W-1:0]       fwd_idx_ff;
   logic [VAL_W-1:0]       fwd_data_ff;
   logic [WW-1:0]          rd_ext;
   logic [WW-1:0]          wr_ext;
   logic [WW-1:0]          rep_ext;
   logic [AW-1:0]          rd_addr;
   logic [AW-1:0]          wr_addr;
   logic [AW-1:0]          rep_addr;
   logic                   rep_ok;
   logic                   do_wr;

   assign rd_ext   = WW'(rd_idx);
   assign wr_ext   = WW'(wr.idx);
   assign rep_ext  = WW'(rep_idx);
   assign rd_addr  = rd_ext[AW-1:0];
   assign wr_addr  = wr_ext[AW-1:0];
   assign rep_addr = rep_ext[AW-1:0];
   assign rep_ok   = 32'(rep_idx) < NUM_ENTRIES;
   assign do_wr    = commit && wr.en;

   // registered read at request time
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= tbl_mem[rd_addr];
      end
   end

   // value after this step: zero if out of range, else own write, then last write, then memory
   always_comb begin
      if (!rep_ok) begin
         entry_value = '0;
      end else if (wr.en && (wr.idx == rep_idx)) begin
         entry_value = wr.data;
      end else if (fwd_vld_ff && (fwd_idx_ff == rep_idx)) begin
         entry_value = fwd_data_ff;
      end else if (vld_ff[rep_addr]) begin
         entry_value = rd_data_ff;
      end else begin
         entry_value = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         tbl_mem[wr_addr] <= wr.data;
         fwd_idx_ff       <= wr.idx;
         fwd_data_ff      <= wr.data;
      end
   end

   // unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         fwd_vld_ff <= 1'b0;
      end else if (do_wr) begin
         vld_ff[wr_addr] <= 1'b1;
         fwd_vld_ff      <= 1'b1;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/knob_filter_soft_takeover.sv
// Top level: two-channel knob filter driving a soft-takeover parameter table.
//
//   channel  dir  payload                                         taken when
//   req_ch   in   operation, sample, param_index, write_value     valid && ready
//   rsp_ch   out  channel, filtered_value, lock_mode,
//                 active_entry, entry_value, index_rejected       valid && ready
//   csr_ch   in   unlock_threshold                                valid (ready tied high)
//
// One request per cycle sustained while responses are accepted; each response is registered
// first in the update stage, which takes the memory read issued with the request, and
// then in the response register.
// The accumulator and table memories are read when a request is taken and
// written back from the update stage; a last-write bypass covers back-to-back hits.
// Reset is synchronous; table and accumulators read as zero.
// A stalled response holds the update stage, which in turn holds off requests.
`default_nettype none
`include "knob_filter_soft_takeover_defines.svh"
module knob_filter_soft_takeover #(
   parameter int NUM_ENTRIES  = 8,
   parameter int FILTER_SHIFT = 6
) (
   input  logic       clock,
   input  logic       reset,
   kfst_req_if.sink   req_ch,
   kfst_rsp_if.source rsp_ch,
   kfst_csr_if.sink   csr_ch
);
   import kfst_pkg::*;

   logic                req_accept;
   logic                smp_accept;
   logic                s1_adv;
   logic [SAMPLE_W-1:0] thresh_ff;
   logic                next_chan_ff;

   logic                s1_valid_ff;
   op_type              s1_op_ff;
   logic [SAMPLE_W-1:0] s1_sample_ff;
   logic [IDX_W-1:0]    s1_idx_ff;
   logic [VAL_W-1:0]    s1_wval_ff;
   logic                s1_ch_ff;

   lock_type            lock_ff;
   lock_type            lock_in;
   logic [SAMPLE_W-1:0] capt_ff;
   logic [SAMPLE_W-1:0] capt_in;
   logic [IDX_W-1:0]    active_ff;
   logic [IDX_W-1:0]    active_in;

   filt_req_type        filt_req;
   logic [SAMPLE_W-1:0] filt_value;
   tbl_wr_type          tbl_wr;
   logic [VAL_W-1:0]    entry_value;
   logic                idx_ok;
   logic                sel_new;
   logic                rej;
   logic                is_sample;
   logic [SAMPLE_W-1:0] gap;

   logic                rsp_valid_ff;
   logic                rsp_chan_ff;
   logic [SAMPLE_W-1:0] rsp_filt_ff;
   logic [MODE_W-1:0]   rsp_mode_ff;
   logic [IDX_W-1:0]    rsp_active_ff;
   logic [VAL_W-1:0]    rsp_entry_ff;
   logic                rsp_rej_ff;

   // handshakes
   assign s1_adv        = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready  = !s1_valid_ff || s1_adv;
   assign req_accept    = req_ch.valid && req_ch.ready;
   assign smp_accept    = req_accept && (op_type'(req_ch.operation) == OP_SAMPLE);
   assign csr_ch.ready  = 1'b1;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_ch.valid) begin
         thresh_ff <= csr_ch.unlock_threshold;
      end
   end

   // channel alternates on every sample taken
   always_ff @(posedge clock) begin
      if (reset) begin
         next_chan_ff <= 1'b0;
      end else if (smp_accept) begin
         next_chan_ff <= ~next_chan_ff;
      end
   end

   // update stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff     <= op_type'(req_ch.operation);
         s1_sample_ff <= req_ch.sample;
         s1_idx_ff    <= req_ch.param_index;
         s1_wval_ff   <= $unsigned(req_ch.write_value);
         s1_ch_ff     <= next_chan_ff;
      end
   end

   assign is_sample = s1_op_ff == OP_SAMPLE;

   assign filt_req.valid = s1_valid_ff && is_sample;
   assign filt_req.ch    = s1_ch_ff;
   assign filt_req.raw   = s1_sample_ff;

   kfst_filter #(
      .FILTER_SHIFT(FILTER_SHIFT)
   ) u_filter (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (smp_accept),
      .rd_ch     (next_chan_ff),
      .req       (filt_req),
      .commit    (s1_adv),
      .filt_value(filt_value)
   );

   assign idx_ok  = 32'(s1_idx_ff) < NUM_ENTRIES;
   assign sel_new = (s1_op_ff == OP_SELECT) && idx_ok && (s1_idx_ff != active_ff);
   assign gap     = (filt_value >= capt_ff) ? (filt_value - capt_ff) : (capt_ff - filt_value);

   // lock control and table write request
   always_comb begin
      lock_in     = lock_ff;
      capt_in     = capt_ff;
      active_in   = active_ff;
      rej         = 1'b0;
      tbl_wr.en   = 1'b0;
      tbl_wr.idx  = s1_idx_ff;
      tbl_wr.data = s1_wval_ff;
      case (s1_op_ff)
         OP_SAMPLE: begin
            if (!s1_ch_ff) begin
               case (lock_ff)
                  LOCK_CAPTURE: begin
                     capt_in = filt_value;
                     lock_in = LOCK_LOCKED;
                  end
                  LOCK_LOCKED: begin
                     if (gap > thresh_ff) begin
                        lock_in = LOCK_TRACKING;
                     end
                  end
                  LOCK_TRACKING: begin
                     tbl_wr.en   = 1'b1;
                     tbl_wr.idx  = active_ff;
                     tbl_wr.data = {{(VAL_W-SAMPLE_W){1'b0}}, filt_value};
                  end
                  default: begin
                     lock_in = lock_ff;
                  end
               endcase
            end
         end
         OP_SELECT: begin
            if (!idx_ok) begin
               rej = 1'b1;
            end else if (sel_new) begin
               active_in = s1_idx_ff;
               lock_in   = LOCK_CAPTURE;
            end
         end
         OP_WRITE: begin
            if (!idx_ok) begin
               rej = 1'b1;
            end else begin
               tbl_wr.en = 1'b1;
            end
         end
         OP_FORCE: begin
            lock_in = LOCK_TRACKING;
         end
         default: begin
            lock_in = lock_ff;
         end
      endcase
   end

   kfst_table #(
      .NUM_ENTRIES(NUM_ENTRIES)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (req_accept),
      .rd_idx     (req_ch.param_index),
      .wr         (tbl_wr),
      .commit     (s1_adv),
      .rep_idx    (s1_idx_ff),
      .entry_value(entry_value)
   );

   // lock state commits with the update stage
   always_ff @(posedge clock) begin
      if (reset) begin
         lock_ff   <= LOCK_CAPTURE;
         capt_ff   <= '0;
         active_ff <= '0;
      end else if (s1_adv) begin
         lock_ff   <= lock_in;
         capt_ff   <= capt_in;
         active_ff <= active_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_chan_ff   <= is_sample ? s1_ch_ff : 1'b0;
         rsp_filt_ff   <= is_sample ? filt_value : '0;
         rsp_mode_ff   <= lock_code(lock_in);
         rsp_active_ff <= active_in;
         rsp_entry_ff  <= entry_value;
         rsp_rej_ff    <= rej;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.channel        = rsp_chan_ff;
   assign rsp_ch.filtered_value = rsp_filt_ff;
   assign rsp_ch.lock_mode      = rsp_mode_ff;
   assign rsp_ch.active_entry   = rsp_active_ff;
   assign rsp_ch.entry_value    = $signed(rsp_entry_ff);
   assign rsp_ch.index_rejected = rsp_rej_ff;

   // a stalled item stays in the update stage
   `KFST_ASSERT(a_s1_hold, clock, reset, s1_valid_ff && !s1_adv |=> s1_valid_ff)
   // selecting a new entry re-arms the lock
   `KFST_ASSERT(a_rearm, clock, reset, s1_adv && sel_new |=> lock_ff == LOCK_CAPTURE)
   // each sample taken flips the channel
   `KFST_ASSERT(a_chan_toggle, clock, reset, smp_accept |=> next_chan_ff != $past(next_chan_ff))

endmodule
`default_nettype wire
